// File: design/ncg_pkg.sv
// Package for the nearest-centroid gesture classifier.
// Holds field widths, register indexes and the trained centroid table.
// No dependencies.
`default_nettype none

package ncg_pkg;

    localparam int SAMPLE_W = 12;   // converter reading
    localparam int CENT_W   = 16;   // centroid, unsigned 12.4
    localparam int DIFF_W   = 17;   // signed 12.4 difference
    localparam int SQ_W     = 32;   // square of a difference, 24.8
    localparam int ACC_W    = 38;   // running squared distance
    localparam int CLASS_W  = 2;    // result field
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CLASS_W-1:0]  NO_OBJECT = 2'd3;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2300;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_THRESHOLD = 1'b0;

    localparam int TRAINED_CLASSES = 3;
    localparam int TRAINED_SAMPLES = 16;

    // Trained centroids in 12.4 fixed point, class-major then by sample position.
    localparam logic [CENT_W-1:0] TRAINED [TRAINED_CLASSES][TRAINED_SAMPLES] = '{
        '{16'd58973, 16'd37785, 16'd38377, 16'd57969, 16'd57375, 16'd31501,
          16'd25731, 16'd57762, 16'd57268, 16'd25171, 16'd31691, 16'd58057,
          16'd58186, 16'd38567, 16'd38081, 16'd59311},
        '{16'd58267, 16'd58303, 16'd58340, 16'd60133, 16'd36701, 16'd21570,
          16'd44909, 16'd23163, 16'd20680, 16'd41847, 16'd23308, 16'd38883,
          16'd59778, 16'd59019, 16'd59003, 16'd59169},
        '{16'd58100, 16'd56896, 16'd57330, 16'd58296, 16'd39546, 16'd28292,
          16'd17861, 16'd52796, 16'd56006, 16'd21724, 16'd26342, 16'd36255,
          16'd58208, 16'd56350, 16'd55695, 16'd56634}
    };

    // Centroid entry for a class and frame position; entries outside the
    // trained table read as zero.
    function automatic logic [CENT_W-1:0] centroid_at(input int unsigned cls,
                                                      input int unsigned pos);
        logic [CENT_W-1:0] v;
        v = '0;
        if (cls < TRAINED_CLASSES && pos < TRAINED_SAMPLES) begin
            v = TRAINED[cls[1:0]][pos[3:0]];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/nearest_centroid_gesture_classifier.sv
// The class appears on m_axis_tvalid once a frame's last sample has passed
// the s1, s2, fin and result registers. Throughput: one sample per cycle; the
// input stalls only while a finished frame waits behind an untaken result.
// Reset (aresetn, synchronous, active low) empties the pipeline, clears the
// frame position, presence count and distance accumulators, and loads the
// presence threshold with 2300.
// Depends on ncg_pkg.
`default_nettype none

module nearest_centroid_gesture_classifier #(
    parameter int FRAME_SAMPLES = 16,
    parameter int CLASS_COUNT   = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Sample request channel.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [11:0] sample, [15:12] zero

    // Result channel.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [1:0] gesture_class, [7:2] zero

    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ncg_pkg::APB_AW-1:0] paddr,
    input  wire logic [ncg_pkg::APB_DW-1:0] pwdata,
    output logic      [ncg_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);

    // Derived widths.
    localparam int POS_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int CNT_W = $clog2(FRAME_SAMPLES + 1);
    localparam int CLS_W = $clog2(CLASS_COUNT);

    localparam int SW = ncg_pkg::SAMPLE_W;
    localparam int AW = ncg_pkg::ACC_W;
    localparam int QW = ncg_pkg::SQ_W;

    // ------------------------------------------------------------------
    // Configuration register. Only the word address bit selects the register;
    // the byte offset bits are ignored, as usual for a word-wide APB slave.
    // ------------------------------------------------------------------
    logic [SW-1:0] threshold_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == ncg_pkg::REG_THRESHOLD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= ncg_pkg::THRESHOLD_RESET;
        end else if (cfg_write) begin
            threshold_reg <= pwdata[SW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ncg_pkg::REG_THRESHOLD) begin
            prdata[SW-1:0] = threshold_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves together; the only thing that
    // holds it is a finished frame that cannot enter the result register
    // because the previous result has not yet been taken.
    // ------------------------------------------------------------------
    logic fin_valid_reg;
    logic advance;

    assign advance       = !(fin_valid_reg && m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = advance;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Stage 1: frame position and presence counting at the input.
    // The presence count saturates at the frame length; only whether it is
    // non-zero matters for the result, and that travels with the last sample.
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic             in_last, in_below;

    logic             s1_valid_reg;
    logic [SW-1:0]    s1_sample_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic             s1_last_reg;
    logic             s1_present_reg;

    assign in_last  = (pos_reg == POS_W'(FRAME_SAMPLES - 1));
    assign in_below = (s_axis_tdata[SW-1:0] < threshold_reg);

    always_comb begin
        count_inc = count_reg;
        if (in_below && count_reg != CNT_W'(FRAME_SAMPLES)) begin
            count_inc = count_reg + CNT_W'(1);
        end
        count_next = in_last ? '0 : count_inc;
        pos_next   = in_last ? '0 : pos_reg + POS_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
            if (accept) begin
                pos_reg   <= pos_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && accept) begin
            s1_sample_reg  <= s_axis_tdata[SW-1:0];
            s1_pos_reg     <= pos_reg;
            s1_last_reg    <= in_last;
            s1_present_reg <= (count_inc != '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: one signed difference and square per class against the
    // centroid at this frame position.
    // ------------------------------------------------------------------
    logic          s2_valid_reg;
    logic          s2_last_reg;
    logic          s2_present_reg;
    logic [QW-1:0] s2_sq_reg [CLASS_COUNT];

    for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_square
        logic [ncg_pkg::CENT_W-1:0]        cent;
        logic signed [ncg_pkg::DIFF_W-1:0] diff;
        logic signed [2*ncg_pkg::DIFF_W-1:0] prod;

        assign cent = ncg_pkg::centroid_at(c, int'(s1_pos_reg));
        assign diff = $signed({1'b0, s1_sample_reg, 4'b0000}) - $signed({1'b0, cent});
        assign prod = diff * diff;

        always_ff @(posedge aclk) begin
            if (advance) begin
                s2_sq_reg[c] <= prod[QW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_last_reg    <= s1_last_reg;
            s2_present_reg <= s1_present_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: accumulate. On the last sample the completed sums move to the
    // final registers and the accumulators restart from zero.
    // ------------------------------------------------------------------
    logic [AW-1:0] acc_reg [CLASS_COUNT];
    logic [AW-1:0] fin_reg [CLASS_COUNT];
    logic          fin_present_reg;
    logic          s2_end;

    assign s2_end = s2_valid_reg && s2_last_reg;

    for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_acc
        logic [AW-1:0] sum;
        assign sum = acc_reg[c] + AW'(s2_sq_reg[c]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                acc_reg[c] <= '0;
            end else if (advance && s2_valid_reg) begin
                acc_reg[c] <= s2_last_reg ? '0 : sum;
            end
        end

        always_ff @(posedge aclk) begin
            if (advance && s2_end) begin
                fin_reg[c] <= sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (advance) begin
            fin_valid_reg <= s2_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s2_end) begin
            fin_present_reg <= s2_present_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick the nearest centroid (strictly smaller wins, so a tie
    // keeps the lower index) and load the result register.
    // ------------------------------------------------------------------
    logic [CLS_W-1:0]            best;
    logic [AW-1:0]               best_dist;
    logic [ncg_pkg::CLASS_W-1:0] class_next;

    always_comb begin
        best      = '0;
        best_dist = fin_reg[0];
        for (int c = 1; c < CLASS_COUNT; c++) begin
            if (fin_reg[c] < best_dist) begin
                best_dist = fin_reg[c];
                best      = CLS_W'(c);
            end
        end
        class_next = fin_present_reg ? ncg_pkg::CLASS_W'(best) : ncg_pkg::NO_OBJECT;
    end

    logic                        m_valid_reg, m_valid_next;
    logic [ncg_pkg::CLASS_W-1:0] m_class_reg;

    assign m_valid_next = (advance && fin_valid_reg) ? 1'b1
                        : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fin_valid_reg) begin
            m_class_reg <= class_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b000000, m_class_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result only ever appears straight after a completed frame.
    a_result_from_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(fin_valid_reg))
        else $error("result appeared without a completed frame");

    // A frame with no sample below the threshold reports nothing present.
    a_no_object: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fin_valid_reg && !fin_present_reg)
            |=> (m_class_reg == ncg_pkg::NO_OBJECT))
        else $error("empty frame did not report no object");

    // A held frame end keeps its sums until it can be delivered.
    a_fin_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_valid_reg && !advance) |=> (fin_valid_reg && $stable(fin_present_reg)))
        else $error("held frame end was lost");

    // The input side never takes a request while the pipeline is held.
    a_no_accept_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(pos_reg) && $stable(count_reg))
        else $error("frame state moved while the pipeline was held");

endmodule

`default_nettype wire
